>>> rtl/ttd_pkg.sv
// Package for the temperature trend detector: shared types and constants.
// No dependencies; used by every other file of the block.
package ttd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int EVAL_CELLS = 16;          // history positions a span can reach
  localparam int PADDR_W    = 5;
  localparam logic [3:0] K_LAST = 4'd15;   // largest neighbor offset probed

  localparam logic signed [SAMPLE_W-1:0] EMPTY_MARK = 16'sh8000;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_WARM_CHANGE = 3'd0;
  localparam logic [2:0] REG_WARM_SPAN   = 3'd1;
  localparam logic [2:0] REG_COOL_CHANGE = 3'd2;
  localparam logic [2:0] REG_COOL_SPAN   = 3'd3;
  localparam logic [2:0] REG_COOL_WINDOW = 3'd4;
  localparam logic [2:0] REG_COOL_LIMIT  = 3'd5;

  typedef struct packed {
    logic [15:0] warm_change;
    logic [3:0]  warm_span;
    logic [15:0] cool_change;
    logic [3:0]  cool_span;
    logic [4:0]  cool_window;
    logic [15:0] cool_limit;
  } cfg_t;

  // compare results of one cell: probe value against own history entry
  typedef struct packed {
    logic steep_cool;  // |p - h| >= cool_limit
    logic steep_warm;  // |p - h| >= warm_change
    logic pos;         // p > h
    logic neg;         // p < h
    logic fall;        // p - h > cool_change
  } cell_flags_t;

  typedef struct packed {
    logic load;  // shift history, reload probe line at offset one
    logic step;  // move probe line one position toward the newest end
  } cell_ctrl_t;

endpackage

>>> rtl/ttd_if.sv
// Stream interfaces for the sample and result channels.
// Depends on ttd_pkg for the sample width.
interface ttd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ttd_pkg::SAMPLE_W-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ttd_out_if;
  logic       valid;
  logic       ready;
  logic       warming;
  logic       cooling;
  logic [4:0] fill_count;

  modport source (output valid, output warming, output cooling, output fill_count,
                  input ready);
  modport sink   (input valid, input warming, input cooling, input fill_count,
                  output ready);
endinterface

>>> rtl/ttd_cfg.sv
// APB-style register bank holding the detector thresholds and spans.
// Depends on ttd_pkg (cfg_t, register indexes).
module ttd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ttd_pkg::cfg_t               cfg_o
);

  ttd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        ttd_pkg::REG_WARM_CHANGE: cfg_nxt.warm_change = pwdata[15:0];
        ttd_pkg::REG_WARM_SPAN:   cfg_nxt.warm_span   = pwdata[3:0];
        ttd_pkg::REG_COOL_CHANGE: cfg_nxt.cool_change = pwdata[15:0];
        ttd_pkg::REG_COOL_SPAN:   cfg_nxt.cool_span   = pwdata[3:0];
        ttd_pkg::REG_COOL_WINDOW: cfg_nxt.cool_window = pwdata[4:0];
        ttd_pkg::REG_COOL_LIMIT:  cfg_nxt.cool_limit  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warm_change <= 16'd16;
      cfg_r.warm_span   <= 4'd3;
      cfg_r.cool_change <= 16'd16;
      cfg_r.cool_span   <= 4'd8;
      cfg_r.cool_window <= 5'd3;
      cfg_r.cool_limit  <= 16'd16;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttd_pkg::REG_WARM_CHANGE: prdata = {16'd0, cfg_r.warm_change};
      ttd_pkg::REG_WARM_SPAN:   prdata = {28'd0, cfg_r.warm_span};
      ttd_pkg::REG_COOL_CHANGE: prdata = {16'd0, cfg_r.cool_change};
      ttd_pkg::REG_COOL_SPAN:   prdata = {28'd0, cfg_r.cool_span};
      ttd_pkg::REG_COOL_WINDOW: prdata = {27'd0, cfg_r.cool_window};
      ttd_pkg::REG_COOL_LIMIT:  prdata = {16'd0, cfg_r.cool_limit};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

>>> rtl/ttd_cell.sv
// One history cell: holds an entry and a probe value that walks down the row,
// and compares the two each cycle. Depends on ttd_pkg.
module ttd_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttd_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [ttd_pkg::SAMPLE_W-1:0] hist_in_i,    // from newer neighbor
  input  logic signed [ttd_pkg::SAMPLE_W-1:0] probe_load_i, // older neighbor's next entry
  input  logic signed [ttd_pkg::SAMPLE_W-1:0] probe_in_i,   // older neighbor's probe
  input  logic [15:0]                         warm_change_i,
  input  logic [15:0]                         cool_change_i,
  input  logic [15:0]                         cool_limit_i,
  output logic signed [ttd_pkg::SAMPLE_W-1:0] hist_o,
  output logic signed [ttd_pkg::SAMPLE_W-1:0] probe_o,
  output ttd_pkg::cell_flags_t                flags_o
);

  logic signed [ttd_pkg::SAMPLE_W-1:0] hist_r, hist_nxt;
  logic signed [ttd_pkg::SAMPLE_W-1:0] probe_r, probe_nxt;
  logic signed [ttd_pkg::SAMPLE_W:0]   diff;
  logic        [ttd_pkg::SAMPLE_W:0]   abs_diff;

  always_comb begin
    hist_nxt  = hist_r;
    probe_nxt = probe_r;
    if (ctrl_i.load) begin
      hist_nxt  = hist_in_i;
      probe_nxt = probe_load_i;
    end else if (ctrl_i.step) begin
      probe_nxt = probe_in_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= ttd_pkg::EMPTY_MARK;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
  end

  assign diff     = {probe_r[15], probe_r} - {hist_r[15], hist_r};
  assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

  assign flags_o.steep_cool = abs_diff >= {1'b0, cool_limit_i};
  assign flags_o.steep_warm = abs_diff >= {1'b0, warm_change_i};
  assign flags_o.pos        = !diff[16] && (diff != 17'sd0);
  assign flags_o.neg        = diff[16];
  assign flags_o.fall       = diff > $signed({1'b0, cool_change_i});

  assign hist_o  = hist_r;
  assign probe_o = probe_r;

endmodule

>>> rtl/ttd_ctrl.sv
// Sequencer: walks the probe offset from 1 to 15, folds the cell flags into
// the warming and cooling decisions and holds the result register.
// Depends on ttd_pkg.
module ttd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttd_pkg::cfg_t        cfg_i,
  input  ttd_pkg::cell_flags_t flags_i [ttd_pkg::EVAL_CELLS],
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  input  logic [4:0]           fill_i,
  output ttd_pkg::cell_ctrl_t  ctrl_o,
  output logic                 out_valid_o,
  output logic                 warming_o,
  output logic                 cooling_o,
  output logic [4:0]           fill_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] k_r, k_nxt;

  logic warm_hit_r, warm_hit_nxt;
  logic warm_gt_r,  warm_gt_nxt;
  logic cool_fall_r, cool_fall_nxt;
  logic any_pos_r, any_pos_nxt;
  logic any_neg_r, any_neg_nxt;
  logic veto_r, veto_nxt;

  logic out_valid_r, out_valid_nxt;
  logic warming_r, cooling_r;
  logic [4:0] fill_out_r;

  logic accept, step, finish;
  logic warm_res, cool_res;
  logic pos_now, neg_now, veto_now;

  assign in_ready_o = (state_r == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_r == ST_EVAL)
                      && !((k_r == ttd_pkg::K_LAST) && out_valid_r && !out_ready_i);
  assign finish     = step && (k_r == ttd_pkg::K_LAST);

  // per-offset reductions over the row
  always_comb begin
    pos_now  = 1'b0;
    neg_now  = 1'b0;
    veto_now = 1'b0;
    for (int i = 0; i < ttd_pkg::EVAL_CELLS; i++) begin
      if (4'(i) < cfg_i.cool_span) begin
        pos_now = pos_now | flags_i[i].pos;
        neg_now = neg_now | flags_i[i].neg;
      end
      // window start i is in range while start + window - 1 <= span
      if ((6'(i) + 6'(cfg_i.cool_window)) <= (6'(cfg_i.cool_span) + 6'd1)) begin
        veto_now = veto_now | flags_i[i].steep_cool;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    warm_hit_nxt  = warm_hit_r;
    warm_gt_nxt   = warm_gt_r;
    cool_fall_nxt = cool_fall_r;
    any_pos_nxt   = any_pos_r;
    any_neg_nxt   = any_neg_r;
    veto_nxt      = veto_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_EVAL;
          k_nxt         = 4'd1;
          warm_hit_nxt  = 1'b0;
          warm_gt_nxt   = 1'b0;
          cool_fall_nxt = 1'b0;
          any_pos_nxt   = 1'b0;
          any_neg_nxt   = 1'b0;
          veto_nxt      = 1'b0;
        end
      end
      ST_EVAL: begin
        if (step) begin
          if (k_r <= cfg_i.warm_span) warm_hit_nxt = warm_hit_r | flags_i[0].steep_warm;
          if (k_r == cfg_i.warm_span) warm_gt_nxt = flags_i[0].neg;
          if (k_r == cfg_i.cool_span) cool_fall_nxt = flags_i[0].fall;
          if (k_r == 4'd1) begin
            any_pos_nxt = pos_now;
            any_neg_nxt = neg_now;
          end
          if ({1'b0, k_r} < cfg_i.cool_window) veto_nxt = veto_r | veto_now;
          if (finish) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign warm_res = (cfg_i.warm_span != 4'd0) && warm_gt_nxt && warm_hit_nxt;
  assign cool_res = (cfg_i.cool_span != 4'd0)
                    && (cfg_i.cool_window <= ({1'b0, cfg_i.cool_span} + 5'd1))
                    && cool_fall_nxt
                    && !(any_pos_nxt && any_neg_nxt)
                    && !veto_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready_i) out_valid_nxt = 1'b0;
    if (finish)                     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    warm_hit_r  <= warm_hit_nxt;
    warm_gt_r   <= warm_gt_nxt;
    cool_fall_r <= cool_fall_nxt;
    any_pos_r   <= any_pos_nxt;
    any_neg_r   <= any_neg_nxt;
    veto_r      <= veto_nxt;
    if (finish) begin
      warming_r  <= warm_res;
      cooling_r  <= cool_res;
      fill_out_r <= fill_i;
    end
  end

  assign ctrl_o.load  = accept;
  assign ctrl_o.step  = step;
  assign out_valid_o  = out_valid_r;
  assign warming_o    = warming_r;
  assign cooling_o    = cooling_r;
  assign fill_count_o = fill_out_r;

endmodule

>>> rtl/temperature_trend_detector_unit.sv
// Temperature trend detector: one result per sample; a new sample is taken only
// after the evaluation of the previous one has finished. The probe line steps
// through offsets 1..15 along the row of cells; the result is registered at
// the last offset, which waits while an earlier result is still not taken.
// Reset (rst_n low, synchronous): history cleared to the empty marker,
// fill count zero, registers to their defaults, no result pending.
module temperature_trend_detector_unit #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ttd_in_if.sink                      in_ch,
  ttd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  ttd_pkg::cfg_t        cfg;
  ttd_pkg::cell_ctrl_t  cell_ctrl;
  ttd_pkg::cell_flags_t cell_flags [HISTORY_DEPTH];
  ttd_pkg::cell_flags_t eval_flags [ttd_pkg::EVAL_CELLS];
  ttd_pkg::cell_flags_t virt_flags;

  logic signed [ttd_pkg::SAMPLE_W-1:0] hist_w  [HISTORY_DEPTH];
  logic signed [ttd_pkg::SAMPLE_W-1:0] probe_w [HISTORY_DEPTH];

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [6:0]        fill_ext;
  logic [4:0]        fill_sat;

  ttd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic signed [ttd_pkg::SAMPLE_W-1:0] hin, pload, pin;
    if (i == 0) begin : g_first
      assign hin = in_ch.sample;
    end else begin : g_mid
      assign hin = hist_w[i-1];
    end
    if (i == HISTORY_DEPTH - 1) begin : g_last
      assign pload = ttd_pkg::EMPTY_MARK;
      assign pin   = ttd_pkg::EMPTY_MARK;
    end else begin : g_inner
      assign pload = hist_w[i];
      assign pin   = probe_w[i+1];
    end
    ttd_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl_i        (cell_ctrl),
      .hist_in_i     (hin),
      .probe_load_i  (pload),
      .probe_in_i    (pin),
      .warm_change_i (cfg.warm_change),
      .cool_change_i (cfg.cool_change),
      .cool_limit_i  (cfg.cool_limit),
      .hist_o        (hist_w[i]),
      .probe_o       (probe_w[i]),
      .flags_o       (cell_flags[i])
    );
  end

  // positions past the history hold the empty marker against itself
  assign virt_flags.steep_cool = (cfg.cool_limit == 16'd0);
  assign virt_flags.steep_warm = (cfg.warm_change == 16'd0);
  assign virt_flags.pos        = 1'b0;
  assign virt_flags.neg        = 1'b0;
  assign virt_flags.fall       = 1'b0;

  for (genvar j = 0; j < ttd_pkg::EVAL_CELLS; j++) begin : g_eval
    if (j < HISTORY_DEPTH) begin : g_real
      assign eval_flags[j] = cell_flags[j];
    end else begin : g_virt
      assign eval_flags[j] = virt_flags;
    end
  end

  // fill count tracks the shift: a marker sample restarts it at zero
  always_comb begin
    fill_nxt = fill_r;
    if (cell_ctrl.load) begin
      if (in_ch.sample == ttd_pkg::EMPTY_MARK) begin
        fill_nxt = '0;
      end else if (fill_r != FILL_W'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign fill_ext = 7'(fill_r);
  assign fill_sat = (fill_ext > 7'd31) ? 5'd31 : fill_ext[4:0];

  ttd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .flags_i      (eval_flags),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .out_ready_i  (out_ch.ready),
    .fill_i       (fill_sat),
    .ctrl_o       (cell_ctrl),
    .out_valid_o  (out_ch.valid),
    .warming_o    (out_ch.warming),
    .cooling_o    (out_ch.cooling),
    .fill_count_o (out_ch.fill_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("sample taken while evaluation in progress");

  // out_ch.valid comes from the registered out_valid_r, set when the last offset finishes
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> ##16 out_ch.valid)
    else $error("no result pending 16 cycles after sample transfer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

endmodule
